// ===== rtl/afc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the 2-D affine transform composer.
// No dependencies; every other file of the block imports this package.
package afc_pkg;

  // Number format: signed Q16.16 words.
  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  // Angle and CORDIC working format: 30 fraction bits.
  localparam int ANG_FRAC     = 30;
  localparam int ANG_W        = 40;
  localparam int CXY_W        = 34;
  localparam int CORDIC_STEPS = 16;
  localparam int ENTRIES      = 9;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [ANG_W-1:0]     ang_t;
  typedef logic signed [CXY_W-1:0]     cxy_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t WORD_ONE = word_t'(64'sd1 <<< FRAC_BITS);

  localparam ang_t ANG_FULL    = ang_t'(64'sd360 <<< FRAC_BITS);
  localparam ang_t ANG_HALF    = ang_t'(64'sd180 <<< FRAC_BITS);
  localparam ang_t ANG_QUARTER = ang_t'(64'sd90 <<< FRAC_BITS);

  // Largest multiple of a full turn used by the range reduction, as a power of two.
  localparam logic [2:0] REDUCE_TOP = 3'd7;
  localparam logic [3:0] LAST_STEP  = 4'(CORDIC_STEPS - 1);
  localparam cxy_t CORDIC_GAIN      = cxy_t'(64'sd652032874);

  // Index of the last product in one dot product.
  localparam logic [1:0] LAST_TERM  = 2'd2;
  localparam logic [1:0] LAST_ROW   = 2'd2;
  localparam logic [3:0] LAST_ENTRY = 4'(ENTRIES - 1);

  typedef enum logic [1:0] {
    OP_IDENTITY  = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_ROTATE    = 2'd2,
    OP_SCALE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ANGLE,
    S_MAC,
    S_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_REDUCE,
    C_FOLD,
    C_ROTATE,
    C_CONVERT
  } cor_state_t;

  // One product request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic       vld;
    logic [1:0] k;
    logic [3:0] dst;
    word_t      a;
    word_t      b;
  } mac_issue_t;

  // One finished matrix entry from the multiply-accumulate unit.
  typedef struct packed {
    logic       vld;
    logic [3:0] dst;
    word_t      value;
  } mac_res_t;

  // Arctangent of 2^-idx in degrees, 30 fraction bits.
  function automatic ang_t atan_deg(input logic [3:0] idx);
    ang_t v;
    case (idx)
      4'd0:    v = ang_t'(64'sd48318382080);
      4'd1:    v = ang_t'(64'sd28524006506);
      4'd2:    v = ang_t'(64'sd15071301663);
      4'd3:    v = ang_t'(64'sd7650428051);
      4'd4:    v = ang_t'(64'sd3840059795);
      4'd5:    v = ang_t'(64'sd1921901881);
      4'd6:    v = ang_t'(64'sd961185453);
      4'd7:    v = ang_t'(64'sd480622056);
      4'd8:    v = ang_t'(64'sd240314695);
      4'd9:    v = ang_t'(64'sd120157806);
      4'd10:   v = ang_t'(64'sd60078960);
      4'd11:   v = ang_t'(64'sd30039487);
      4'd12:   v = ang_t'(64'sd15019745);
      4'd13:   v = ang_t'(64'sd7509872);
      4'd14:   v = ang_t'(64'sd3754936);
      4'd15:   v = ang_t'(64'sd1877468);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Full turn times 2^idx, for the compare-and-subtract reduction.
  function automatic ang_t reduce_step(input logic [2:0] idx);
    return ANG_FULL <<< idx;
  endfunction

  // Saturating word addition: the two top bits of the widened sum differ on overflow.
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return s[WORD_BITS-1:0];
  endfunction

  // Saturating negation.
  function automatic word_t sat_neg(input word_t a);
    if (a == WORD_MIN) return WORD_MAX;
    return -a;
  endfunction

  // Q30 CORDIC output to a word: round half up, then saturate.
  function automatic word_t q30_to_word(input cxy_t v);
    cxy_t t;
    t = (v + (cxy_t'(1) <<< (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS);
    if (t > cxy_t'(WORD_MAX)) return WORD_MAX;
    if (t < cxy_t'(WORD_MIN)) return WORD_MIN;
    return t[WORD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/affine_2d_transform_composer_top.sv =====
// Top level of the 2-D affine transform composer: sequencer, matrix state and
// output register. Depends on afc_pkg, afc_cordic and afc_mac.
//
// Usage: the block holds a 3x3 Q16.16 homogeneous matrix, the identity after
// reset. Each input beat (in_valid/in_ready) carries one operation: identity
// reloads the unit matrix; translate, scale and rotate post-multiply the
// matrix by the matching elementary matrix. Each input beat yields exactly
// one output beat (out_valid/out_ready) carrying all nine entries of the new
// matrix in row-major order.
// On an input beat, identity goes straight to the done state; translate and
// scale issue 27 products one per cycle to the single shared multiplier, then
// pass through its three-stage pipeline and the output hand-over; rotate first
// computes sine and cosine in 8 reduction steps, a fold, 16 CORDIC steps, a
// conversion and a hand-over, and then issues its 27 products in the same way.
// One item is worked on at a time; in_ready is high only while the sequencer
// is idle. The output register lets the next item be accepted while a result
// is still waiting; if that item finishes before the result is taken, the
// block holds it until out_ready. Reset (rst_n low, synchronous) returns the
// matrix to identity and drops any item in flight.
module affine_2d_transform_composer_top
  import afc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  word_t       in_x_value,
  input  word_t       in_y_value,
  input  word_t       in_angle_degrees,
  output logic        out_valid,
  input  logic        out_ready,
  output word_t       out_entry_r0c0,
  output word_t       out_entry_r0c1,
  output word_t       out_entry_r0c2,
  output word_t       out_entry_r1c0,
  output word_t       out_entry_r1c1,
  output word_t       out_entry_r1c2,
  output word_t       out_entry_r2c0,
  output word_t       out_entry_r2c1,
  output word_t       out_entry_r2c2
);

  seq_state_t state_r, state_nxt;
  op_t        op_r;
  word_t      xv_r, yv_r;
  word_t      mat_r [ENTRIES];
  word_t      res_r [ENTRIES];
  word_t      out_r [ENTRIES];
  logic       out_valid_r;
  logic [1:0] i_r, j_r, k_r;
  logic       iss_end_r;
  logic [3:0] res_cnt_r;

  logic       in_fire;
  logic       out_load;
  logic       cor_start;
  logic       cor_done;
  word_t      cos_v, sin_v;
  logic [3:0] a_idx;
  word_t      e_val;
  mac_issue_t issue;
  mac_res_t   mac_out;

  // Sine and cosine unit.
  afc_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (in_angle_degrees),
    .done    (cor_done),
    .cos_val (cos_v),
    .sin_val (sin_v)
  );

  // Shared multiply-accumulate unit.
  afc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .result (mac_out)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake controls.
  always_comb begin
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    in_fire   = in_valid && in_ready;
    cor_start = in_fire && (op_t'(in_operation) == OP_ROTATE);
    out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (op_t'(in_operation))
            OP_IDENTITY: state_nxt = S_DONE;
            OP_ROTATE:   state_nxt = S_ANGLE;
            default:     state_nxt = S_MAC;
          endcase
        end
      end
      S_ANGLE: if (cor_done) state_nxt = S_MAC;
      S_MAC:   if (mac_out.vld && (res_cnt_r == LAST_ENTRY)) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Elementary matrix entry at row k, column j.
  always_comb begin
    e_val = (k_r == j_r) ? WORD_ONE : '0;
    case (op_r)
      OP_TRANSLATE: begin
        if (j_r == 2'd2 && k_r == 2'd0) e_val = xv_r;
        if (j_r == 2'd2 && k_r == 2'd1) e_val = yv_r;
      end
      OP_ROTATE: begin
        if (k_r == 2'd0 && j_r == 2'd0) e_val = cos_v;
        if (k_r == 2'd0 && j_r == 2'd1) e_val = sat_neg(sin_v);
        if (k_r == 2'd1 && j_r == 2'd0) e_val = sin_v;
        if (k_r == 2'd1 && j_r == 2'd1) e_val = cos_v;
      end
      OP_SCALE: begin
        if (k_r == 2'd0 && j_r == 2'd0) e_val = xv_r;
        if (k_r == 2'd1 && j_r == 2'd1) e_val = yv_r;
      end
      default: ;
    endcase
  end

  // Product request: current matrix entry (i, k) times elementary entry (k, j).
  always_comb begin
    a_idx      = 4'(i_r) * 4'd3 + 4'(k_r);
    issue.vld  = (state_r == S_MAC) && !iss_end_r;
    issue.k    = k_r;
    issue.dst  = 4'(i_r) * 4'd3 + 4'(j_r);
    issue.a    = mat_r[a_idx];
    issue.b    = e_val;
  end

  // Operand latch on an input beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= op_t'(in_operation);
      xv_r <= in_x_value;
      yv_r <= in_y_value;
    end
  end

  // Issue counters walk k fastest, then j, then i.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_end_r <= 1'b0;
    end else if (in_fire) begin
      i_r       <= 2'd0;
      j_r       <= 2'd0;
      k_r       <= 2'd0;
      iss_end_r <= 1'b0;
    end else if (issue.vld) begin
      if (k_r == LAST_TERM) begin
        k_r <= 2'd0;
        if (j_r == LAST_TERM) begin
          j_r <= 2'd0;
          if (i_r == LAST_ROW) begin
            iss_end_r <= 1'b1;
          end else begin
            i_r <= i_r + 2'd1;
          end
        end else begin
          j_r <= j_r + 2'd1;
        end
      end else begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  // Count of finished entries for the running item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 4'd0;
    end else if (in_fire) begin
      res_cnt_r <= 4'd0;
    end else if (mac_out.vld) begin
      res_cnt_r <= res_cnt_r + 4'd1;
    end
  end

  // New matrix collects here until the item is complete.
  always_ff @(posedge clk) begin
    if (in_fire && (op_t'(in_operation) == OP_IDENTITY)) begin
      for (int n = 0; n < ENTRIES; n++) begin
        res_r[n] <= (n % 4 == 0) ? WORD_ONE : '0;
      end
    end else if (mac_out.vld) begin
      res_r[mac_out.dst] <= mac_out.value;
    end
  end

  // Current matrix, identity after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < ENTRIES; n++) begin
        mat_r[n] <= (n % 4 == 0) ? WORD_ONE : '0;
      end
    end else if (out_load) begin
      mat_r <= res_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_entry_r0c0 = out_r[0];
  assign out_entry_r0c1 = out_r[1];
  assign out_entry_r0c2 = out_r[2];
  assign out_entry_r1c0 = out_r[3];
  assign out_entry_r1c1 = out_r[4];
  assign out_entry_r1c2 = out_r[5];
  assign out_entry_r2c0 = out_r[6];
  assign out_entry_r2c1 = out_r[7];
  assign out_entry_r2c2 = out_r[8];

endmodule

// ===== rtl/afc_cordic.sv =====
// Iterative sine/cosine unit: angle reduction by compare-and-subtract, then a
// rotation-mode CORDIC with one shift-add step per cycle. Depends on afc_pkg.
module afc_cordic
  import afc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t angle,
  output logic  done,
  output word_t cos_val,
  output word_t sin_val
);

  cor_state_t state_r, state_nxt;
  logic [3:0] cnt_r;
  ang_t       z_r;
  cxy_t       x_r, y_r;
  logic       flip_r;
  logic       done_r;
  word_t      cos_r, sin_r;

  ang_t       red_step;
  ang_t       fold1, fold2;
  logic       fold_flip;
  cxy_t       xs, ys;
  ang_t       atan_v;
  cxy_t       xf, yf;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE:    if (start) state_nxt = C_REDUCE;
      C_REDUCE:  if (cnt_r == 4'd0) state_nxt = C_FOLD;
      C_FOLD:    state_nxt = C_ROTATE;
      C_ROTATE:  if (cnt_r == LAST_STEP) state_nxt = C_CONVERT;
      C_CONVERT: state_nxt = C_IDLE;
      default:   state_nxt = C_IDLE;
    endcase
  end

  // Shared shift-add datapath terms.
  always_comb begin
    red_step = reduce_step(cnt_r[2:0]);
    // Fold into (-180, 180], then into [-90, 90]; a half-turn fold flips both outputs.
    fold1 = (z_r > ANG_HALF) ? z_r - ANG_FULL : z_r;
    fold2 = fold1;
    fold_flip = 1'b0;
    if (fold1 > ANG_QUARTER) begin
      fold2 = fold1 - ANG_HALF;
      fold_flip = 1'b1;
    end else if (fold1 < -ANG_QUARTER) begin
      fold2 = fold1 + ANG_HALF;
      fold_flip = 1'b1;
    end
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    atan_v = atan_deg(cnt_r);
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: begin
        if (start) begin
          // Bias negative angles by a large multiple of a full turn.
          z_r   <= ang_t'(angle) + (angle[WORD_BITS-1] ? reduce_step(REDUCE_TOP) : ang_t'(0));
          cnt_r <= {1'b0, REDUCE_TOP};
        end
      end
      C_REDUCE: begin
        if (z_r >= red_step) z_r <= z_r - red_step;
        cnt_r <= cnt_r - 4'd1;
      end
      C_FOLD: begin
        z_r    <= fold2 <<< (ANG_FRAC - FRAC_BITS);
        flip_r <= fold_flip;
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        cnt_r  <= 4'd0;
      end
      C_ROTATE: begin
        // A zero residual counts as positive.
        if (!z_r[ANG_W-1]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_v;
        end
        cnt_r <= cnt_r + 4'd1;
      end
      C_CONVERT: begin
        cos_r <= q30_to_word(xf);
        sin_r <= q30_to_word(yf);
      end
      default: ;
    endcase
  end

  // Completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (state_r == C_CONVERT);
    end
  end

  assign done    = done_r;
  assign cos_val = cos_r;
  assign sin_val = sin_r;

endmodule

// ===== rtl/afc_mac.sv =====
// Shared multiply-accumulate unit: one Q16.16 product per beat, rounded and
// saturated, summed with saturation over three terms. Depends on afc_pkg.
module afc_mac
  import afc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mac_issue_t issue,
  output mac_res_t   result
);

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int Q_W    = PROD_W - FRAC_BITS;

  logic [WORD_BITS-1:0] mag_a, mag_b;
  logic [PROD_W-1:0]    prod;

  logic                 p_vld_r;
  logic                 p_neg_r;
  logic [1:0]           p_k_r;
  logic [3:0]           p_dst_r;
  logic [PROD_W-1:0]    p_prod_r;

  logic [PROD_W-1:0]    rnd;
  logic [Q_W-1:0]       q, lim, qs;
  word_t                term;

  logic                 t_vld_r;
  logic [1:0]           t_k_r;
  logic [3:0]           t_dst_r;
  word_t                t_val_r;

  word_t                acc_r, acc_nxt;
  mac_res_t             res_r;

  // Magnitudes and the unsigned product.
  always_comb begin
    mag_a = issue.a[WORD_BITS-1] ? WORD_BITS'(-issue.a) : WORD_BITS'(issue.a);
    mag_b = issue.b[WORD_BITS-1] ? WORD_BITS'(-issue.b) : WORD_BITS'(issue.b);
    prod  = {{WORD_BITS{1'b0}}, mag_a} * {{WORD_BITS{1'b0}}, mag_b};
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= issue.vld;
    end
    p_neg_r  <= issue.a[WORD_BITS-1] ^ issue.b[WORD_BITS-1];
    p_k_r    <= issue.k;
    p_dst_r  <= issue.dst;
    p_prod_r <= prod;
  end

  // Round the magnitude half away from zero, saturate, reapply the sign.
  always_comb begin
    rnd  = p_prod_r + (PROD_W'(1) << (FRAC_BITS - 1));
    q    = rnd[PROD_W-1:FRAC_BITS];
    lim  = Q_W'(WORD_MAX) + Q_W'(p_neg_r);
    qs   = (q > lim) ? lim : q;
    term = p_neg_r ? -word_t'(qs[WORD_BITS-1:0]) : word_t'(qs[WORD_BITS-1:0]);
  end

  // Term stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= p_vld_r;
    end
    t_k_r   <= p_k_r;
    t_dst_r <= p_dst_r;
    t_val_r <= term;
  end

  // Saturating accumulation; the first term of a dot product restarts the sum.
  always_comb begin
    acc_nxt = (t_k_r == 2'd0) ? t_val_r : sat_add(acc_r, t_val_r);
  end

  // Accumulator and result register; a result is flagged on the last term.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r.vld <= t_vld_r && (t_k_r == LAST_TERM);
    end
    if (t_vld_r) acc_r <= acc_nxt;
    res_r.dst   <= t_dst_r;
    res_r.value <= acc_nxt;
  end

  assign result = res_r;

endmodule

// ===== sim/affine_2d_transform_composer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for affine_2d_transform_composer_top: a directed table, then random beats.
// It depends on afc_pkg and the RTL, and keeps its own fixed-point model of the 3x3 matrix.
module affine_2d_transform_composer_top_tb;
  import afc_pkg::*;

  typedef logic [0:8][WORD_BITS-1:0] mat_t;

  typedef struct packed {
    op_t   op;
    word_t x;
    word_t y;
    word_t ang;
    logic  typed;
    mat_t  mat;
  } plan_row_t;

  localparam int     RANDOM_BEATS = 1428;
  localparam int     QUIET_TAIL   = 150;
  localparam int     CYCLE_LIMIT  = 600000;
  localparam int     SETTLE_CYCLES = 100;
  localparam longint WMAX_L    = 64'sd2147483647;
  localparam longint WMIN_L    = -64'sd2147483648;
  localparam longint ONE_L     = 64'sd1 <<< FRAC_BITS;
  localparam longint FULL_L    = 64'sd360 <<< FRAC_BITS;
  localparam longint HALF_L    = 64'sd180 <<< FRAC_BITS;
  localparam longint QUARTER_L = 64'sd90 <<< FRAC_BITS;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint ATAN_Q30 [16] = '{
    64'sd48318382080, 64'sd28524006506, 64'sd15071301663, 64'sd7650428051,
    64'sd3840059795, 64'sd1921901881, 64'sd961185453, 64'sd480622056,
    64'sd240314695, 64'sd120157806, 64'sd60078960, 64'sd30039487,
    64'sd15019745, 64'sd7509872, 64'sd3754936, 64'sd1877468
  };
  localparam word_t DEG  = word_t'(1 << FRAC_BITS);
  localparam word_t ZW   = '0;
  localparam mat_t  UNIT_MAT = {WORD_ONE, ZW, ZW, ZW, WORD_ONE, ZW, ZW, ZW, WORD_ONE};

  logic  clk;
  logic  rst_n            = 1'b0;
  logic  in_valid         = 1'b0;
  logic  in_ready;
  logic  [1:0] in_operation = '0;
  word_t in_x_value       = '0;
  word_t in_y_value       = '0;
  word_t in_angle_degrees = '0;
  logic  out_valid;
  logic  out_ready        = 1'b1;
  word_t out_entry_r0c0, out_entry_r0c1, out_entry_r0c2;
  word_t out_entry_r1c0, out_entry_r1c1, out_entry_r1c2;
  word_t out_entry_r2c0, out_entry_r2c1, out_entry_r2c2;

  // Model state and scoreboard.
  longint    cur_m [9];
  mat_t      pending_mats [$];
  plan_row_t step_plan [$];
  int        beats_per_op [4];
  int        mats_checked = 0;
  int        errors       = 0;
  int        cycle_count  = 0;
  bit        idle_on      = 1'b1;

  affine_2d_transform_composer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_x_value       (in_x_value),
    .in_y_value       (in_y_value),
    .in_angle_degrees (in_angle_degrees),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_entry_r0c0   (out_entry_r0c0),
    .out_entry_r0c1   (out_entry_r0c1),
    .out_entry_r0c2   (out_entry_r0c2),
    .out_entry_r1c0   (out_entry_r1c0),
    .out_entry_r1c1   (out_entry_r1c1),
    .out_entry_r1c2   (out_entry_r1c2),
    .out_entry_r2c0   (out_entry_r2c0),
    .out_entry_r2c1   (out_entry_r2c1),
    .out_entry_r2c2   (out_entry_r2c2)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp a wide value to the signed word range.
  function automatic longint clip_word(input longint v);
    if (v > WMAX_L) return WMAX_L;
    if (v < WMIN_L) return WMIN_L;
    return v;
  endfunction

  // Fixed-point product: magnitude rounded to nearest with ties away from zero, then saturated.
  function automatic longint q_mul(input longint a, input longint b);
    longint      p;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] lim;
    logic        neg;
    p   = a * b;
    neg = (a < 0) != (b < 0);
    mag = (p < 0) ? -p : p;
    q   = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = 64'(WMAX_L) + (neg ? 64'd1 : 64'd0);
    if (q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Apply one operation to the model matrix and return the matrix the block should report.
  function automatic mat_t compose_step(input op_t op, input word_t xv, input word_t yv,
                                        input word_t av);
    longint e [9];
    longint nxt [9];
    longint acc, r, z, cx, cy, nx, sn, cs;
    bit     flip;
    mat_t   m;
    int     i, j, k;
    for (k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? ONE_L : 64'sd0;
    flip = 1'b0;
    case (op)
      OP_IDENTITY: begin
        for (k = 0; k < 9; k++) cur_m[k] = e[k];
      end
      OP_TRANSLATE: begin
        e[2] = xv;
        e[5] = yv;
      end
      OP_SCALE: begin
        e[0] = xv;
        e[4] = yv;
      end
      default: begin
        // Reduce into [0, 360), then fold into [-90, 90]; a half-turn fold negates both.
        r = longint'(av) % FULL_L;
        if (r < 0) r += FULL_L;
        if (r > HALF_L) r -= FULL_L;
        if (r > QUARTER_L) begin
          r -= HALF_L;
          flip = 1'b1;
        end else if (r < -QUARTER_L) begin
          r += HALF_L;
          flip = 1'b1;
        end
        z  = r <<< (ANG_FRAC - FRAC_BITS);
        cx = GAIN_Q30;
        cy = 0;
        // Rotation-mode iterations; a zero residual counts as positive.
        for (i = 0; i < CORDIC_STEPS; i++) begin
          if (z >= 0) begin
            nx = cx - (cy >>> i);
            cy = cy + (cx >>> i);
            z  = z - ATAN_Q30[i];
          end else begin
            nx = cx + (cy >>> i);
            cy = cy - (cx >>> i);
            z  = z + ATAN_Q30[i];
          end
          cx = nx;
        end
        if (flip) begin
          cx = -cx;
          cy = -cy;
        end
        cs = clip_word((cx + (64'sd1 <<< (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS));
        sn = clip_word((cy + (64'sd1 <<< (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS));
        e[0] = cs;
        e[1] = (sn == WMIN_L) ? WMAX_L : -sn;
        e[3] = sn;
        e[4] = cs;
      end
    endcase
    // Post-multiply, summing the three products in order with saturation at each add.
    if (op != OP_IDENTITY) begin
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          acc = q_mul(cur_m[3*i], e[j]);
          acc = clip_word(acc + q_mul(cur_m[3*i+1], e[3+j]));
          acc = clip_word(acc + q_mul(cur_m[3*i+2], e[6+j]));
          nxt[3*i+j] = acc;
        end
      end
      for (k = 0; k < 9; k++) cur_m[k] = nxt[k];
    end
    for (k = 0; k < 9; k++) m[k] = cur_m[k][WORD_BITS-1:0];
    return m;
  endfunction

  function automatic plan_row_t plan_row(input op_t op, input word_t x, input word_t y,
                                         input word_t ang, input logic typed, input mat_t mat);
    plan_row_t pr;
    pr.op    = op;
    pr.x     = x;
    pr.y     = y;
    pr.ang   = ang;
    pr.typed = typed;
    pr.mat   = mat;
    return pr;
  endfunction

  // Random word: mostly small Q16.16 values so matrices stay meaningful, some full-range
  // noise and some extremes.
  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0, 1: return word_t'($urandom);
      2: begin
        case ($urandom_range(0, 5))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return WORD_ONE;
          3:       return -WORD_ONE;
          4:       return word_t'(1 << (FRAC_BITS - 1));
          default: return ZW;
        endcase
      end
      default: return word_t'($urandom_range(0, 1 << (FRAC_BITS + 3)) - (1 << (FRAC_BITS + 2)));
    endcase
  endfunction

  // Random angle: full range, exact multiples of 45 degrees, or fractional within two turns.
  function automatic word_t pick_angle();
    case ($urandom_range(0, 5))
      0, 1: return word_t'($urandom);
      2:    return word_t'(($urandom_range(0, 16) - 8) * (45 << FRAC_BITS));
      default: return word_t'($urandom_range(0, 1440 << FRAC_BITS) - (720 << FRAC_BITS));
    endcase
  endfunction

  // Offer one input beat, optionally after an idle burst, and record its expected matrix.
  task automatic send_beat(input op_t op, input word_t xv, input word_t yv, input word_t av,
                           input logic typed, input mat_t typed_mat);
    int   gap;
    mat_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_x_value       <= xv;
    in_y_value       <= yv;
    in_angle_degrees <= av;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = compose_step(op, xv, yv, av);
    pending_mats.push_back(typed ? typed_mat : predicted);
    beats_per_op[op]++;
  endtask

  // Hold the input side idle until every outstanding matrix has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_mats.size() != 0);
  endtask

  // Stimulus: reset, directed table, random beats, then the end of the run.
  initial begin
    int     n;
    int     pick;
    op_t    op;
    for (n = 0; n < 4; n++) beats_per_op[n] = 0;
    for (n = 0; n < 9; n++) cur_m[n] = (n % 4 == 0) ? ONE_L : 64'sd0;

    // Extremes, ignored-field junk, rounding ties and the special angles.
    step_plan.push_back(plan_row(OP_IDENTITY, 32'h1234_5678, 32'hDEAD_BEEF, WORD_MAX, 1'b1,
                                 UNIT_MAT));
    step_plan.push_back(plan_row(OP_TRANSLATE, WORD_MAX, WORD_MIN, WORD_MIN, 1'b1,
                                 {WORD_ONE, ZW, WORD_MAX, ZW, WORD_ONE, WORD_MIN,
                                  ZW, ZW, WORD_ONE}));
    step_plan.push_back(plan_row(OP_TRANSLATE, WORD_MAX, WORD_MIN, ZW, 1'b0, '0));
    step_plan.push_back(plan_row(OP_IDENTITY, ZW, ZW, ZW, 1'b1, UNIT_MAT));
    step_plan.push_back(plan_row(OP_SCALE, WORD_MAX, WORD_MIN, 32'h5555_AAAA, 1'b1,
                                 {WORD_MAX, ZW, ZW, ZW, WORD_MIN, ZW, ZW, ZW, WORD_ONE}));
    step_plan.push_back(plan_row(OP_SCALE, WORD_MIN, WORD_MIN, ZW, 1'b0, '0));
    step_plan.push_back(plan_row(OP_SCALE, ZW, ZW, ZW, 1'b0, '0));
    step_plan.push_back(plan_row(OP_IDENTITY, WORD_MIN, WORD_MAX, WORD_MIN, 1'b1, UNIT_MAT));
    step_plan.push_back(plan_row(OP_SCALE, word_t'(1 << (FRAC_BITS - 1)), -word_t'(1), ZW,
                                 1'b0, '0));
    step_plan.push_back(plan_row(OP_SCALE, word_t'(1), word_t'(1), ZW, 1'b0, '0));
    step_plan.push_back(plan_row(OP_IDENTITY, ZW, ZW, ZW, 1'b1, UNIT_MAT));
    step_plan.push_back(plan_row(OP_ROTATE, WORD_MAX, WORD_MIN, 180 * DEG, 1'b0, '0));
    step_plan.push_back(plan_row(OP_ROTATE, ZW, ZW, 90 * DEG, 1'b0, '0));
    step_plan.push_back(plan_row(OP_ROTATE, ZW, ZW, -(90 * DEG), 1'b0, '0));
    step_plan.push_back(plan_row(OP_ROTATE, ZW, ZW, ZW, 1'b0, '0));
    step_plan.push_back(plan_row(OP_ROTATE, ZW, ZW, 360 * DEG, 1'b0, '0));
    step_plan.push_back(plan_row(OP_ROTATE, ZW, ZW, WORD_MAX, 1'b0, '0));
    step_plan.push_back(plan_row(OP_ROTATE, ZW, ZW, WORD_MIN, 1'b0, '0));
    step_plan.push_back(plan_row(OP_ROTATE, ZW, ZW, 45 * DEG + word_t'(1), 1'b0, '0));
    step_plan.push_back(plan_row(OP_ROTATE, ZW, ZW, 270 * DEG, 1'b0, '0));
    step_plan.push_back(plan_row(OP_ROTATE, ZW, ZW, -(180 * DEG), 1'b0, '0));
    step_plan.push_back(plan_row(OP_TRANSLATE, WORD_ONE, -WORD_ONE, WORD_MAX, 1'b0, '0));
    step_plan.push_back(plan_row(OP_SCALE, 2 * WORD_ONE, -3 * WORD_ONE, ZW, 1'b0, '0));
    step_plan.push_back(plan_row(OP_IDENTITY, ZW, ZW, ZW, 1'b1, UNIT_MAT));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (step_plan[n]) begin
      send_beat(step_plan[n].op, step_plan[n].x, step_plan[n].y, step_plan[n].ang,
                step_plan[n].typed, step_plan[n].mat);
    end
    drain_results();

    // Random beats: identity now and then so the matrix does not stay saturated.
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n >= RANDOM_BEATS - QUIET_TAIL) idle_on = 1'b0;
      else if (n % 100 == 0) idle_on = ($urandom_range(0, 9) < 7);
      if (n == RANDOM_BEATS / 2) drain_results();
      pick = $urandom_range(0, 19);
      if (pick < 2)       op = OP_IDENTITY;
      else if (pick < 8)  op = OP_TRANSLATE;
      else if (pick < 14) op = OP_ROTATE;
      else                op = OP_SCALE;
      send_beat(op, pick_value(), pick_value(), pick_angle(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Let everything come back, then allow for a late extra beat.
    while (pending_mats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d beats: %0d identity, %0d translate, %0d rotate, %0d scale.",
             beats_per_op[0] + beats_per_op[1] + beats_per_op[2] + beats_per_op[3],
             beats_per_op[0], beats_per_op[1], beats_per_op[2], beats_per_op[3]);
    $display("Compared %0d result matrices with %0d mismatching beats.", mats_checked, errors);
    if (errors == 0) begin
      $display("affine_2d_transform_composer_top test passed");
    end else begin
      $display("affine_2d_transform_composer_top test failed");
    end
    $finish;
  end

  // Result side back-pressure in random bursts.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (idle_on && stall == 0 && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expected matrix.
  always @(posedge clk) begin
    mat_t got;
    mat_t want;
    bit   bad;
    if (rst_n && out_valid && out_ready) begin
      got = {out_entry_r0c0, out_entry_r0c1, out_entry_r0c2,
             out_entry_r1c0, out_entry_r1c1, out_entry_r1c2,
             out_entry_r2c0, out_entry_r2c1, out_entry_r2c2};
      if (pending_mats.size() == 0) begin
        $display("%0t ns: result beat with no matrix expected, got r0c0 %0d", $time,
                 $signed(got[0]));
        errors++;
      end else begin
        want = pending_mats.pop_front();
        bad  = 1'b0;
        for (int k = 0; k < 9; k++) begin
          if (got[k] !== want[k]) begin
            $display("%0t ns: entry r%0dc%0d mismatch, expected %0d, got %0d", $time,
                     k / 3, k % 3, $signed(want[k]), $signed(got[k]));
            bad = 1'b1;
          end
        end
        if (bad) errors++;
        mats_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d matrices outstanding.", cycle_count,
               pending_mats.size());
      $display("affine_2d_transform_composer_top test failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/afc_pkg.sv
rtl/afc_cordic.sv
rtl/afc_mac.sv
rtl/affine_2d_transform_composer_top.sv
sim/affine_2d_transform_composer_top_tb.sv
